FILE: design/ndss_pkg.sv
// Shared types, constants and arithmetic helpers for the nonlinear diffusion stencil step.
// No dependencies; every other file in this folder refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package ndss_pkg;

    localparam int LD_W          = 16;
    localparam int CD_W          = 16;
    localparam int STEP_W        = 36;
    localparam int ROW_OUT_W     = 12;
    localparam int COL_OUT_W     = 11;
    localparam int WIDTH_CFG_W   = 12;
    localparam int HEIGHT_CFG_W  = 13;
    localparam int APB_DATA_W    = 32;
    localparam int ADDR_W        = 3;
    localparam int REG_SEL_BIT   = 2;
    localparam int NUM_RES       = 3;
    localparam int TERMS_PER_RES = 4;
    localparam int OPND_W        = 17;
    localparam int PROD_W        = 35;
    localparam int SUM_W         = 37;
    localparam int IDX_W         = 2;

    localparam logic [WIDTH_CFG_W-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [HEIGHT_CFG_W-1:0] HEIGHT_RESET = 13'd480;

    typedef enum logic
    {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_idx_t;

    typedef struct packed
    {
        logic signed [LD_W-1:0] img;
        logic [CD_W-1:0]        cond;
    } pixel_t;

    // One line-buffer word: the row above and the row above that, same column.
    typedef struct packed
    {
        pixel_t newer;
        pixel_t older;
    } entry_t;

    typedef struct packed
    {
        logic [OPND_W-1:0]        csum;
        logic signed [OPND_W-1:0] ldiff;
    } term_t;

    typedef term_t [TERMS_PER_RES-1:0] term_set_t;
    typedef term_set_t [NUM_RES-1:0]   term_grid_t;

    typedef struct packed
    {
        logic [ROW_OUT_W-1:0] row;
        logic [COL_OUT_W-1:0] col;
    } tag_t;

    typedef struct packed
    {
        logic [IDX_W-1:0]     last;
        tag_t [NUM_RES-1:0]   tag;
    } meta_t;

    typedef logic [TERMS_PER_RES-1:0][PROD_W-1:0] prod_set_t;

    typedef struct packed
    {
        logic [NUM_RES-1:0][STEP_W-1:0] val;
        meta_t                          meta;
    } bundle_t;

    // Operands of one flux term; a dropped neighbor gives an all-zero term.
    function automatic term_t make_term(pixel_t ctr, pixel_t nb, logic en);
        term_t t;
        t.csum  = {1'b0, ctr.cond} + {1'b0, nb.cond};
        t.ldiff = {nb.img[LD_W-1], nb.img} - {ctr.img[LD_W-1], ctr.img};
        if (!en)
        begin
            t = '0;
        end
        return t;
    endfunction

    function automatic logic [PROD_W-1:0] term_product(term_t t);
        logic signed [PROD_W-1:0] a;
        logic signed [PROD_W-1:0] b;
        a = {{(PROD_W-OPND_W){1'b0}}, t.csum};
        b = {{(PROD_W-OPND_W){t.ldiff[OPND_W-1]}}, t.ldiff};
        return a * b;
    endfunction

    function automatic logic [STEP_W-1:0] sum_products(prod_set_t p);
        logic signed [SUM_W-1:0] s;
        s = '0;
        for (int k = 0; k < TERMS_PER_RES; k++)
        begin
            s = s + {{(SUM_W-PROD_W){p[k][PROD_W-1]}}, p[k]};
        end
        return s[STEP_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: design/ndss_ifs.sv
// Stream interfaces of the stencil step: pixel pairs in, diffusion increments out.
// Depends on ndss_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ndss_pix_if;
    logic                             valid;
    logic                             ready;
    logic signed [ndss_pkg::LD_W-1:0] ld_sample;
    logic [ndss_pkg::CD_W-1:0]        cond_sample;

    modport source (output valid, output ld_sample, output cond_sample, input ready);
    modport sink   (input valid, input ld_sample, input cond_sample, output ready);
endinterface

interface ndss_res_if;
    logic                               valid;
    logic                               ready;
    logic signed [ndss_pkg::STEP_W-1:0] step_value;
    logic [ndss_pkg::ROW_OUT_W-1:0]     row_index;
    logic [ndss_pkg::COL_OUT_W-1:0]     col_index;
    logic                               end_of_run;

    modport source (output valid, output step_value, output row_index, output col_index,
                    output end_of_run, input ready);
    modport sink   (input valid, input step_value, input row_index, input col_index,
                    input end_of_run, output ready);
endinterface

`default_nettype wire

FILE: design/ndss_line.sv
// Line buffer: one word per column holding the two previous rows, with same-cycle forwarding.
// Depends on ndss_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module ndss_line #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic [AW-1:0]    waddr,
    input  wire ndss_pkg::entry_t wdata,
    input  wire logic [AW-1:0]    raddr,
    output ndss_pkg::entry_t      rdata
);

    ndss_pkg::entry_t line_ram [DEPTH];
    ndss_pkg::entry_t q_reg;
    ndss_pkg::entry_t fwd_data_reg;
    logic             fwd_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            line_ram[waddr] <= wdata;
            q_reg           <= line_ram[raddr];
            fwd_data_reg    <= wdata;
        end
    end

    // A read of the word written in the same cycle returns the new word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (en)
        begin
            fwd_reg <= (raddr == waddr);
        end
    end

    assign rdata = fwd_reg ? fwd_data_reg : q_reg;

endmodule

`default_nettype wire

FILE: design/ndss_flux.sv
// Flux arithmetic pipeline: a product stage, then a sum stage that also serves as output register.
// Depends on ndss_pkg for term, product and bundle types and helpers.
`timescale 1ns / 1ps
`default_nettype none

module ndss_flux (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire ndss_pkg::term_grid_t in_terms,
    input  wire ndss_pkg::meta_t      in_meta,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output ndss_pkg::bundle_t         out_bundle
);

    ndss_pkg::prod_set_t [ndss_pkg::NUM_RES-1:0] prod_reg;
    ndss_pkg::prod_set_t [ndss_pkg::NUM_RES-1:0] prod_next;
    ndss_pkg::meta_t                             meta_reg;
    ndss_pkg::bundle_t                           bundle_reg;
    ndss_pkg::bundle_t                           bundle_next;
    logic                                        prod_valid_reg;
    logic                                        out_valid_reg;
    logic                                        sum_ready;

    assign sum_ready = !out_valid_reg || out_ready;
    assign in_ready  = !prod_valid_reg || sum_ready;

    always_comb
    begin
        for (int r = 0; r < ndss_pkg::NUM_RES; r++)
        begin
            for (int k = 0; k < ndss_pkg::TERMS_PER_RES; k++)
            begin
                prod_next[r][k] = ndss_pkg::term_product(in_terms[r][k]);
            end
        end
    end

    always_comb
    begin
        bundle_next.meta = meta_reg;
        for (int r = 0; r < ndss_pkg::NUM_RES; r++)
        begin
            bundle_next.val[r] = ndss_pkg::sum_products(prod_reg[r]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                prod_valid_reg <= in_valid;
            end
            if (sum_ready)
            begin
                out_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            prod_reg <= prod_next;
            meta_reg <= in_meta;
        end
        if (sum_ready && prod_valid_reg)
        begin
            bundle_reg <= bundle_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_bundle = bundle_reg;

endmodule

`default_nettype wire

FILE: design/nonlinear_diffusion_stencil_step_top.sv
// Top level of the streaming 5-point nonlinear diffusion step (explicit flux increment).
// Depends on ndss_pkg, ndss_ifs (stream interfaces), ndss_line and ndss_flux.
//
//   Channel   Direction  Beat contents
//   pixel     in         ld_sample (Q3.12, signed), cond_sample (Q1.15, unsigned)
//   result    out        step_value (27 fraction bits), row_index, col_index, end_of_run
//   APB       in/out     image_width at 0x0, image_height at 0x4 (write takes effect
//                        at the access cycle; reads return the stored value)
//
// A pixel beat can be accepted every cycle unless result stalls hold it; its results leave
// from the output register, after the operand and product registers. Inner rows give one
// result per beat and the first row none, so the block streams one pixel per cycle; in the
// last row beats past column 0 give two results (three on the final pixel), and the single
// result beat per cycle then sets the pace. Reset clears the counters, the pixel history and
// the pipeline valids; the line buffer needs no clearing as no result uses an unwritten word.
// Stalls on the result side fill the pipeline stages before pixel ready drops.
`timescale 1ns / 1ps
`default_nettype none

module nonlinear_diffusion_stencil_step_top #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    ndss_pix_if.sink                                 pixel,
    ndss_res_if.source                               result,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [ndss_pkg::ADDR_W-1:0]         paddr,
    input  wire logic [ndss_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ndss_pkg::APB_DATA_W-1:0]          prdata,
    output logic                                     pready
);

    localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;

    // ------------------------------------------------------------------
    // Configuration registers. The register is selected by one address
    // bit; the low byte-lane bits are ignored.
    // ------------------------------------------------------------------
    logic [ndss_pkg::WIDTH_CFG_W-1:0]  width_reg;
    logic [ndss_pkg::HEIGHT_CFG_W-1:0] height_reg;
    logic                              cfg_wr;
    ndss_pkg::reg_idx_t                cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = ndss_pkg::reg_idx_t'(paddr[ndss_pkg::REG_SEL_BIT]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= ndss_pkg::WIDTH_RESET;
            height_reg <= ndss_pkg::HEIGHT_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_sel)
                ndss_pkg::REG_IMAGE_WIDTH:
                begin
                    width_reg <= pwdata[ndss_pkg::WIDTH_CFG_W-1:0];
                end
                ndss_pkg::REG_IMAGE_HEIGHT:
                begin
                    height_reg <= pwdata[ndss_pkg::HEIGHT_CFG_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            ndss_pkg::REG_IMAGE_WIDTH:  prdata = ndss_pkg::APB_DATA_W'(width_reg);
            ndss_pkg::REG_IMAGE_HEIGHT: prdata = ndss_pkg::APB_DATA_W'(height_reg);
            default:                    prdata = '0;
        endcase
    end

    // The programmed sizes are clamped to [2, maximum]; the counters compare
    // against the index of the last column and the last row.
    logic [CW-1:0] last_col_idx;
    logic [RW-1:0] last_row_idx;

    always_comb
    begin
        if (width_reg < ndss_pkg::WIDTH_CFG_W'(2))
        begin
            last_col_idx = CW'(1);
        end
        else if (int'(width_reg) > MAX_WIDTH)
        begin
            last_col_idx = CW'(MAX_WIDTH - 1);
        end
        else
        begin
            last_col_idx = CW'(width_reg - ndss_pkg::WIDTH_CFG_W'(1));
        end

        if (height_reg < ndss_pkg::HEIGHT_CFG_W'(2))
        begin
            last_row_idx = RW'(1);
        end
        else if (int'(height_reg) > MAX_HEIGHT)
        begin
            last_row_idx = RW'(MAX_HEIGHT - 1);
        end
        else
        begin
            last_row_idx = RW'(height_reg - ndss_pkg::HEIGHT_CFG_W'(1));
        end
    end

    // ------------------------------------------------------------------
    // Position counters and the window around the current column.
    // The line buffer word at column j holds {row i-1, row i-2}. On the
    // beat at column j the word is rewritten as {row i, row i-1}, so the
    // left neighbor of the previous row must come from lft_reg, not the
    // buffer. The buffer is read two columns ahead (wrapping into the
    // next row) so that the right neighbor is present when the beat lands.
    // ------------------------------------------------------------------
    logic [CW-1:0]          col_reg;
    logic [RW-1:0]          row_reg;
    ndss_pkg::pixel_t       hist0_reg;
    ndss_pkg::pixel_t       hist1_reg;
    ndss_pkg::entry_t       ctr_reg;
    ndss_pkg::pixel_t       lft_reg;
    ndss_pkg::entry_t       rd_entry;
    ndss_pkg::entry_t       wr_entry;
    ndss_pkg::pixel_t       cur;
    logic [CW-1:0]          rd_addr;
    logic [CW:0]            col_p1;
    logic                   accept;
    logic                   last_col;
    logic                   last_row;

    assign cur.img  = pixel.ld_sample;
    assign cur.cond = pixel.cond_sample;
    assign last_col = col_reg >= last_col_idx;
    assign last_row = row_reg >= last_row_idx;
    assign col_p1   = {1'b0, col_reg} + (CW+1)'(1);

    always_comb
    begin
        if (last_col)
        begin
            rd_addr = CW'(1);
        end
        else if (col_p1 == {1'b0, last_col_idx})
        begin
            rd_addr = '0;
        end
        else
        begin
            rd_addr = CW'(col_p1 + (CW+1)'(1));
        end
    end

    assign wr_entry.newer = cur;
    assign wr_entry.older = ctr_reg.newer;

    ndss_line #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (accept),
        .waddr (col_reg),
        .wdata (wr_entry),
        .raddr (rd_addr),
        .rdata (rd_entry)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            hist0_reg <= '0;
            hist1_reg <= '0;
        end
        else if (accept)
        begin
            hist1_reg <= hist0_reg;
            hist0_reg <= cur;
            if (last_col)
            begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_reg <= col_p1[CW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lft_reg <= ctr_reg.newer;
            ctr_reg <= rd_entry;
        end
    end

    // ------------------------------------------------------------------
    // Term operands. Result A is the pixel one row up (its down neighbor
    // is this beat). In the last row, result B is the previous pixel of
    // this row and result C the final pixel of the frame.
    // ------------------------------------------------------------------
    ndss_pkg::term_grid_t  terms;
    ndss_pkg::meta_t       meta;
    logic                  has_a;
    logic                  has_b;
    logic                  has_c;
    logic                  col_nz;
    ndss_pkg::term_grid_t  s1_terms_reg;
    ndss_pkg::meta_t       s1_meta_reg;
    logic                  s1_valid_reg;
    logic                  flux_ready;

    assign col_nz = col_reg != '0;
    assign has_a  = row_reg != '0;
    assign has_b  = has_a && last_row && col_nz;
    assign has_c  = has_a && last_row && last_col;

    always_comb
    begin
        terms[0][0] = ndss_pkg::make_term(ctr_reg.newer, rd_entry.newer, !last_col);
        terms[0][1] = ndss_pkg::make_term(ctr_reg.newer, cur, 1'b1);
        terms[0][2] = ndss_pkg::make_term(ctr_reg.newer, lft_reg, col_nz);
        terms[0][3] = ndss_pkg::make_term(ctr_reg.newer, ctr_reg.older, row_reg > RW'(1));

        terms[1][0] = ndss_pkg::make_term(hist0_reg, cur, 1'b1);
        terms[1][1] = ndss_pkg::make_term(hist0_reg, hist1_reg, col_reg > CW'(1));
        terms[1][2] = ndss_pkg::make_term(hist0_reg, lft_reg, 1'b1);
        terms[1][3] = '0;

        terms[2][0] = ndss_pkg::make_term(cur, hist0_reg, col_nz);
        terms[2][1] = ndss_pkg::make_term(cur, ctr_reg.newer, 1'b1);
        terms[2][2] = '0;
        terms[2][3] = '0;

        meta.tag[0].row = ndss_pkg::ROW_OUT_W'(row_reg - RW'(1));
        meta.tag[0].col = ndss_pkg::COL_OUT_W'(col_reg);
        meta.tag[1].row = ndss_pkg::ROW_OUT_W'(row_reg);
        meta.tag[1].col = ndss_pkg::COL_OUT_W'(col_reg - CW'(1));
        meta.tag[2].row = ndss_pkg::ROW_OUT_W'(row_reg);
        meta.tag[2].col = ndss_pkg::COL_OUT_W'(col_reg);

        if (has_c)
        begin
            meta.last = ndss_pkg::IDX_W'(2);
        end
        else if (has_b)
        begin
            meta.last = ndss_pkg::IDX_W'(1);
        end
        else
        begin
            meta.last = '0;
        end
    end

    // Operand stage: beats of the first row carry no result and stop here.
    assign pixel.ready = !s1_valid_reg || flux_ready;
    assign accept      = pixel.valid && pixel.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (pixel.ready)
        begin
            s1_valid_reg <= pixel.valid && has_a;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_terms_reg <= terms;
            s1_meta_reg  <= meta;
        end
    end

    // ------------------------------------------------------------------
    // Products, sums, and the output register.
    // ------------------------------------------------------------------
    ndss_pkg::bundle_t bundle;
    logic              bundle_valid;
    logic              bundle_done;
    logic [ndss_pkg::IDX_W-1:0] idx_reg;

    ndss_flux u_flux (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s1_valid_reg),
        .in_ready   (flux_ready),
        .in_terms   (s1_terms_reg),
        .in_meta    (s1_meta_reg),
        .out_valid  (bundle_valid),
        .out_ready  (bundle_done),
        .out_bundle (bundle)
    );

    // The output register holds all results of one beat; idx_reg walks them.
    assign bundle_done  = result.ready && (idx_reg == bundle.meta.last);
    assign result.valid = bundle_valid;
    assign result.end_of_run = idx_reg == bundle.meta.last;

    always_comb
    begin
        case (idx_reg)
            ndss_pkg::IDX_W'(0):
            begin
                result.step_value = $signed(bundle.val[0]);
                result.row_index  = bundle.meta.tag[0].row;
                result.col_index  = bundle.meta.tag[0].col;
            end
            ndss_pkg::IDX_W'(1):
            begin
                result.step_value = $signed(bundle.val[1]);
                result.row_index  = bundle.meta.tag[1].row;
                result.col_index  = bundle.meta.tag[1].col;
            end
            default:
            begin
                result.step_value = $signed(bundle.val[2]);
                result.row_index  = bundle.meta.tag[2].row;
                result.col_index  = bundle.meta.tag[2].col;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (result.valid && result.ready)
        begin
            idx_reg <= bundle_done ? '0 : idx_reg + ndss_pkg::IDX_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> idx_reg <= bundle.meta.last)
        else $error("result index runs past the last result of the beat");

    a_idx_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |=> $stable(idx_reg))
        else $error("result index moved without a result beat");

    a_first_row_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && row_reg == '0) |=> !s1_valid_reg)
        else $error("first-row pixel produced a result");

    a_inner_row_single: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && row_reg != '0 && !last_row) |=> (s1_valid_reg && s1_meta_reg.last == '0))
        else $error("inner-row pixel did not produce exactly one result");

endmodule

`default_nettype wire
